/* rtl/utlc_pkg.sv */
// types and constants shared by the tank level classifier modules
`timescale 1ns / 1ps
package utlc_pkg;

    localparam int ECHO_W   = 16;
    localparam int DIST_W   = 21;
    localparam int LEVEL_W  = 10;
    localparam int CLASS_W  = 3;
    localparam int COUNT_W  = 8;
    localparam int HEIGHT_W = 10;
    localparam int PCT_W    = 7;
    localparam int DEPTH_W  = 20;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 10;
    localparam int OUT_DW   = 48;

    localparam int DIV_STEPS = DEPTH_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [DIST_W-1:0]  DIST_SAT      = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 10'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [COUNT_W-1:0] ERROR_LIMIT   = 8'd5;
    localparam logic [DEPTH_W-1:0] MCM_PER_CM    = 20'd1000;

    localparam logic [CFG_AW-1:0] REG_TANK_HEIGHT = 3'd0;
    localparam logic [CFG_AW-1:0] REG_EMPTY_MAX   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LOW_MAX     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_HALF_MAX    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_HIGH_MAX    = 3'd4;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 10'd100;
    localparam logic [PCT_W-1:0]    EMPTY_MAX_RESET = 7'd10;
    localparam logic [PCT_W-1:0]    LOW_MAX_RESET   = 7'd30;
    localparam logic [PCT_W-1:0]    HALF_MAX_RESET  = 7'd60;
    localparam logic [PCT_W-1:0]    HIGH_MAX_RESET  = 7'd90;

    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_ERROR   = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_EMPTY   = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_LOW     = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_HALF    = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_HIGH    = 3'd5;
    localparam logic [CLASS_W-1:0] CLASS_FULL    = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_DEPTH,
        ST_DIV,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height_cm;
        logic [PCT_W-1:0]    empty_max_pct;
        logic [PCT_W-1:0]    low_max_pct;
        logic [PCT_W-1:0]    half_max_pct;
        logic [PCT_W-1:0]    high_max_pct;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic calc_dist;
        logic div_init;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic timeout;
        logic div_last;
        logic out_busy;
    } stat_t;

endpackage

/* rtl/ultrasonic_tank_level_classifier.sv */
// Ultrasonic tank level classifier top level. After acceptance a valid
// reading goes through a step for distance and tank height in thousandths
// of a cm, a step to form the depth, 20 steps of the bit-serial restoring
// divider that yields the level, and a step to classify and update the
// held state. A timeout (zero width) skips the depth and divider steps.
// No new reading is taken while one is in progress; input is accepted again
// once the result has been registered. The result waits in an output register
// until taken, and the next result is held back only if the previous
// transaction is still pending.
`timescale 1ns / 1ps
module ultrasonic_tank_level_classifier
    import utlc_pkg::*;
#(
    parameter int ECHO_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ECHO_W-1:0] s_tdata,   // echo_width_us
    output logic              m_tvalid,
    input  logic              m_tready,
    // distance_mcm, level_permille, level_class, error_count, zero pad
    output logic [OUT_DW-1:0] m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    utlc_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    utlc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    utlc_dp #(
        .ECHO_BITS (ECHO_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .echo_in  (s_tdata),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/utlc_regs.sv */
// configuration register file for height and class thresholds
`timescale 1ns / 1ps
module utlc_regs
    import utlc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                REG_TANK_HEIGHT: cfg_next.height_cm      = cfg_data[HEIGHT_W-1:0];
                REG_EMPTY_MAX:   cfg_next.empty_max_pct  = cfg_data[PCT_W-1:0];
                REG_LOW_MAX:     cfg_next.low_max_pct    = cfg_data[PCT_W-1:0];
                REG_HALF_MAX:    cfg_next.half_max_pct   = cfg_data[PCT_W-1:0];
                REG_HIGH_MAX:    cfg_next.high_max_pct   = cfg_data[PCT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.height_cm      <= HEIGHT_RESET;
            cfg_reg.empty_max_pct  <= EMPTY_MAX_RESET;
            cfg_reg.low_max_pct    <= LOW_MAX_RESET;
            cfg_reg.half_max_pct   <= HALF_MAX_RESET;
            cfg_reg.high_max_pct   <= HIGH_MAX_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/utlc_ctrl.sv */
// sequencing state machine for one reading
`timescale 1ns / 1ps
module utlc_ctrl
    import utlc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DIST;
            end
            ST_DIST: begin
                state_next = stat.timeout ? ST_COMMIT : ST_DEPTH;
            end
            ST_DEPTH: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_last) state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIST:   cmd.calc_dist = 1'b1;
            ST_DEPTH:  cmd.div_init  = 1'b1;
            ST_DIV:    cmd.div_step  = 1'b1;
            ST_COMMIT: cmd.commit    = !stat.out_busy;
            default: begin
                s_tready = 1'b0;
                cmd      = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/utlc_dp.sv */
// distance, depth, bit-serial level divider, classification and held state
`timescale 1ns / 1ps
module utlc_dp
    import utlc_pkg::*;
#(
    parameter int ECHO_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [ECHO_W-1:0] echo_in,
    input  cfg_t              cfg,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata
);

    localparam int USED_BITS = (ECHO_BITS < ECHO_W) ? ECHO_BITS : ECHO_W;
    localparam int PROD_W    = DIST_W + 5;
    localparam int PAD_W     = OUT_DW - DIST_W - LEVEL_W - CLASS_W - COUNT_W;

    logic [USED_BITS-1:0] width_reg;
    logic                 timeout_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [DEPTH_W-1:0]   hmcm_reg;
    logic [DEPTH_W-1:0]   quot_reg;
    logic [HEIGHT_W-1:0]  rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [COUNT_W-1:0]   fail_run_reg;
    logic [DIST_W-1:0]    held_distance_reg;
    logic [LEVEL_W-1:0]   held_level_reg;
    logic [CLASS_W-1:0]   held_class_reg;
    logic                 m_tvalid_reg;
    logic [OUT_DW-1:0]    m_tdata_reg;

    logic [PROD_W-1:0]    prod;
    logic [DIST_W-1:0]    dist_next;
    logic [DEPTH_W-1:0]   hmcm_next;
    logic [DEPTH_W-1:0]   depth;
    logic [HEIGHT_W:0]    rem_shift;
    logic                 rem_ge;
    logic [LEVEL_W-1:0]   level;
    logic [PCT_W+3:0]     lvl_cmp;
    logic [CLASS_W-1:0]   class_new;
    logic [COUNT_W-1:0]   fail_run_next;
    logic [DIST_W-1:0]    held_distance_next;
    logic [LEVEL_W-1:0]   held_level_next;
    logic [CLASS_W-1:0]   held_class_next;

    // distance = width * 17, saturated to the field width
    assign prod      = (PROD_W'(width_reg) << 4) + PROD_W'(width_reg);
    assign dist_next = (prod > PROD_W'(DIST_SAT)) ? DIST_SAT : prod[DIST_W-1:0];
    assign hmcm_next = DEPTH_W'(cfg.height_cm) * MCM_PER_CM;

    assign depth = (dist_reg >= DIST_W'(hmcm_reg)) ? '0
                 : hmcm_reg - dist_reg[DEPTH_W-1:0];

    // restoring divide step
    assign rem_shift = {rem_reg, quot_reg[DEPTH_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, cfg.height_cm};

    always_comb begin
        if (cfg.height_cm == '0) begin
            level = '0;
        end else if (quot_reg > DEPTH_W'(LEVEL_MAX)) begin
            level = LEVEL_MAX;
        end else begin
            level = quot_reg[LEVEL_W-1:0];
        end
    end

    assign lvl_cmp = (PCT_W+4)'(level);

    always_comb begin
        if (lvl_cmp <= (PCT_W+4)'(cfg.empty_max_pct) * (PCT_W+4)'(10)) begin
            class_new = CLASS_EMPTY;
        end else if (lvl_cmp <= (PCT_W+4)'(cfg.low_max_pct) * (PCT_W+4)'(10)) begin
            class_new = CLASS_LOW;
        end else if (lvl_cmp <= (PCT_W+4)'(cfg.half_max_pct) * (PCT_W+4)'(10)) begin
            class_new = CLASS_HALF;
        end else if (lvl_cmp <= (PCT_W+4)'(cfg.high_max_pct) * (PCT_W+4)'(10)) begin
            class_new = CLASS_HIGH;
        end else begin
            class_new = CLASS_FULL;
        end
    end

    always_comb begin
        fail_run_next      = fail_run_reg;
        held_distance_next = held_distance_reg;
        held_level_next    = held_level_reg;
        held_class_next    = held_class_reg;
        if (timeout_reg) begin
            if (fail_run_reg != COUNT_MAX) fail_run_next = fail_run_reg + 1'b1;
            if (fail_run_next > ERROR_LIMIT) held_class_next = CLASS_ERROR;
        end else begin
            fail_run_next      = '0;
            held_distance_next = dist_reg;
            held_level_next    = level;
            held_class_next    = class_new;
        end
    end

    assign stat.timeout  = timeout_reg;
    assign stat.div_last = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            width_reg   <= echo_in[USED_BITS-1:0];
            timeout_reg <= echo_in[USED_BITS-1:0] == '0;
        end
        if (cmd.calc_dist) begin
            dist_reg <= dist_next;
            hmcm_reg <= hmcm_next;
        end
        if (cmd.div_init) begin
            quot_reg    <= depth;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            quot_reg    <= {quot_reg[DEPTH_W-2:0], rem_ge};
            rem_reg     <= rem_ge ? HEIGHT_W'(rem_shift - {1'b0, cfg.height_cm})
                                  : rem_shift[HEIGHT_W-1:0];
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.commit) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, fail_run_next, held_class_next,
                            held_level_next, held_distance_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_run_reg      <= '0;
            held_distance_reg <= '0;
            held_level_reg    <= '0;
            held_class_reg    <= CLASS_UNKNOWN;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cmd.commit) begin
                fail_run_reg      <= fail_run_next;
                held_distance_reg <= held_distance_next;
                held_level_reg    <= held_level_next;
                held_class_reg    <= held_class_next;
                m_tvalid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg      <= 1'b0;
            end
        end
    end

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid_reg && !m_tready))
        else $error("result committed over an untaken transaction");

    a_good_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !timeout_reg) |=> fail_run_reg == '0)
        else $error("valid reading did not clear the error count");

    a_error_class: assert property (@(posedge aclk) disable iff (!aresetn)
        held_class_reg == CLASS_ERROR |-> fail_run_reg > ERROR_LIMIT)
        else $error("error class without enough timeouts");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_level_reg <= LEVEL_MAX)
        else $error("held level above full scale");

endmodule
